[sv/rsnh_pkg.sv]
// ----------------------------------------------------------------------------
// rsnh_pkg: shared definitions for the ray/sphere nearest hit unit
// Field widths, default parameter values, saturation limits and the status
// struct that the serial arithmetic units report to the sequencer.
// ----------------------------------------------------------------------------
package rsnh_pkg;

    // Default parameter values.
    localparam int DEF_MAX_SPHERES = 1024;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths.
    localparam int COORD_W = 32;
    localparam int IDX_W   = 10;
    localparam int DIST_W  = 32;

    // Width of the exact sum of three 32 x 32 products.
    localparam int SUM_W = 66;

    // Saturation limits of a root.
    localparam logic [DIST_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] SAT_MIN = 32'h8000_0000;

    // Status of one serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[sv/rsnh_serial_mul.sv]
// ----------------------------------------------------------------------------
// rsnh_serial_mul: bit-serial unsigned multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle and
// holds the full product until the next start.
// ----------------------------------------------------------------------------
module rsnh_serial_mul #(
    parameter int W = 49
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [W-1:0]        a_in,
    input  logic [W-1:0]        b_in,
    output rsnh_pkg::unit_stat_t stat,
    output logic [2*W-1:0]      product
);

    localparam int CNT_W = $clog2(W);

    logic [2*W-1:0] p_reg;
    logic [W-1:0]   mc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W-1:0]   addend;
    logic [W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set.
    always_comb begin
        addend = p_reg[0] ? mc_reg : '0;
        sum    = {1'b0, p_reg[2*W-1:W]} + {1'b0, addend};
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Product shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            p_reg  <= {{W{1'b0}}, b_in};
            mc_reg <= a_in;
        end else if (busy_reg) begin
            p_reg <= {sum, p_reg[W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = p_reg;

endmodule

[sv/rsnh_serial_sqrt.sv]
// ----------------------------------------------------------------------------
// rsnh_serial_sqrt: digit-by-digit integer square root
// Takes two radicand bits per cycle and produces one root bit per cycle,
// giving floor(sqrt(d_in)).
// ----------------------------------------------------------------------------
module rsnh_serial_sqrt #(
    parameter int R_W = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [2*R_W-1:0]    d_in,
    output rsnh_pkg::unit_stat_t stat,
    output logic [R_W-1:0]      root
);

    localparam int D_W   = 2 * R_W;
    localparam int CNT_W = $clog2(R_W);

    logic [D_W-1:0]   d_sh_reg;
    logic [R_W+1:0]   rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [R_W+3:0]   rem_t;
    logic [R_W+3:0]   trial;
    logic [R_W+3:0]   diff;
    logic             ge;

    // One root digit: try 4*root+1 against the shifted remainder.
    always_comb begin
        rem_t = {rem_reg, d_sh_reg[D_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = rem_t - trial;
        ge    = (rem_t >= trial);
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(R_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Radicand, remainder and root shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            d_sh_reg <= d_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            d_sh_reg <= {d_sh_reg[D_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[R_W+1:0] : rem_t[R_W+1:0];
            root_reg <= {root_reg[R_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

[sv/rsnh_serial_div.sv]
// ----------------------------------------------------------------------------
// rsnh_serial_div: restoring unsigned divider
// Shifts one dividend bit into the remainder per cycle and one quotient bit
// into the same shift register, then reports quotient and remainder flag.
// ----------------------------------------------------------------------------
module rsnh_serial_div #(
    parameter int DV_W = 67,
    parameter int DS_W = 49
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DV_W-1:0]     dividend,
    input  logic [DS_W-1:0]     divisor,
    output rsnh_pkg::unit_stat_t stat,
    output logic [DV_W-1:0]     quotient,
    output logic                rem_nz
);

    localparam int CNT_W = $clog2(DV_W);

    logic [DV_W-1:0]  q_sh_reg;
    logic [DS_W-1:0]  rem_reg;
    logic [DS_W-1:0]  dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DS_W:0]    r_t;
    logic [DS_W:0]    diff;
    logic             ge;

    // One quotient bit per step.
    always_comb begin
        r_t  = {rem_reg, q_sh_reg[DV_W-1]};
        diff = r_t - {1'b0, dsr_reg};
        ge   = (r_t >= {1'b0, dsr_reg});
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend/quotient and remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_sh_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            q_sh_reg <= {q_sh_reg[DV_W-2:0], ge};
            rem_reg  <= ge ? diff[DS_W-1:0] : r_t[DS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_sh_reg;
    assign rem_nz    = (rem_reg != '0);

endmodule

[sv/ray_sphere_nearest_hit_unit.sv]
// Items are taken one at a time: s_ready is high only in the idle state, so a new item waits
// until the last one has passed all phases and its result has entered the output register.
// A miss found at the coefficient check or the discriminant ends early.
// The done state waits while the output register is full and m_ready is low. The shared
// multiplier forms eleven products per item.
// Reset (aresetn, synchronous, active low) clears the nearest-hit state.
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit_unit: ray against unit sphere, nearest hit per ray
// Forms a, h and c of the quadratic with a serial multiplier, finds the
// discriminant root and both roots serially, and keeps the nearest
// non-negative root across the spheres of one ray.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_hit_unit #(
    parameter int MAX_SPHERES = rsnh_pkg::DEF_MAX_SPHERES,
    parameter int FRAC_BITS   = rsnh_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_origin_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_origin_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_origin_z,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_dir_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_dir_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_dir_z,
    input  logic        [rsnh_pkg::IDX_W-1:0]   s_sphere_index,
    input  logic                                s_last_sphere,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rsnh_pkg::DIST_W-1:0]  m_root_near,
    output logic signed [rsnh_pkg::DIST_W-1:0]  m_root_far,
    output logic                                m_roots_valid,
    output logic signed [rsnh_pkg::DIST_W-1:0]  m_best_distance,
    output logic        [rsnh_pkg::IDX_W-1:0]   m_best_sphere,
    output logic                                m_best_valid,
    output logic                                m_ray_done
);

    localparam int CW     = rsnh_pkg::COORD_W;
    localparam int DW     = rsnh_pkg::DIST_W;
    localparam int IW     = rsnh_pkg::IDX_W;
    localparam int SUM_W  = rsnh_pkg::SUM_W;
    localparam int COEF_W = SUM_W - FRAC_BITS;
    localparam int MAG_W  = COEF_W - 1;
    localparam int ROOT_W = MAG_W + 1;
    localparam int D_W    = 2 * ROOT_W;
    localparam int N_W    = ROOT_W + 1;
    localparam int DV_W   = N_W + FRAC_BITS;

    // Product slots of the dot phase.
    localparam logic [3:0] K_A_LAST = 4'd2;
    localparam logic [3:0] K_H_LAST = 4'd5;
    localparam logic [3:0] K_C_LAST = 4'd8;

    localparam logic [COEF_W-1:0] ONE_Q = COEF_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_CHECK,
        S_HH,
        S_AC,
        S_SQRT,
        S_DIV_N,
        S_DIV_F,
        S_DONE
    } state_t;

    state_t state_reg;

    // Captured item.
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic [IW-1:0]        idx_reg;
    logic                 last_reg;

    // Working registers.
    logic [3:0]               k_reg;
    logic                     issued_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [COEF_W-1:0] a_reg, h_reg, c_reg;
    logic [2*MAG_W-1:0]       hh_reg;
    logic [D_W-1:0]           d_reg;
    logic signed [N_W:0]      nn_reg, nf_reg;
    logic signed [DW-1:0]     tn_reg, tf_reg;
    logic                     valid_reg;

    // Nearest-hit state.
    logic signed [DW-1:0] best_dist_reg;
    logic [IW-1:0]        best_sph_reg;
    logic                 best_found_reg;

    // Output register.
    logic                 m_valid_reg;
    logic signed [DW-1:0] m_root_near_reg, m_root_far_reg, m_best_distance_reg;
    logic                 m_roots_valid_reg, m_best_valid_reg, m_ray_done_reg;
    logic [IW-1:0]        m_best_sphere_reg;

    // Unit connections.
    logic                   mul_start, sqrt_start, div_start;
    logic [MAG_W-1:0]       mul_a, mul_b;
    logic [2*MAG_W-1:0]     mul_prod;
    rsnh_pkg::unit_stat_t   mul_stat, sqrt_stat, div_stat;
    logic [ROOT_W-1:0]      sqrt_root;
    logic [DV_W-1:0]        div_dividend, div_q;
    logic                   div_rem_nz;

    // Combinational helpers.
    logic signed [CW-1:0]     x_op, y_op;
    logic [CW-1:0]            x_neg, y_neg, x_mag, y_mag;
    logic [SUM_W-1:0]         prod_ext, term, acc_total;
    logic [COEF_W-1:0]        coef_now;
    logic [COEF_W-1:0]        h_neg, c_neg;
    logic [MAG_W-1:0]         h_mag, c_mag;
    logic                     a_ok, idx_ok, c_le0;
    logic [2*MAG_W-1:0]       ac;
    logic [D_W-1:0]           d_sum, d_diff;
    logic                     disc_neg;
    logic [N_W:0]             h_ext, s_ext, nn_now, nf_now;
    logic [N_W:0]             n_sel, n_neg;
    logic [N_W-1:0]           n_mag;
    logic                     q_hi_nz;
    logic [DW-1:0]            q_lo, t_sat;
    logic                     has_cand, upd;
    logic signed [DW-1:0]     cand;
    logic signed [DW-1:0]     new_dist;
    logic [IW-1:0]            new_sph;
    logic                     new_found;
    logic                     out_free;

    // Operand selection for the nine dot-product terms.
    always_comb begin
        case (k_reg)
            4'd0:    begin x_op = dx_reg; y_op = dx_reg; end
            4'd1:    begin x_op = dy_reg; y_op = dy_reg; end
            4'd2:    begin x_op = dz_reg; y_op = dz_reg; end
            4'd3:    begin x_op = dx_reg; y_op = ox_reg; end
            4'd4:    begin x_op = dy_reg; y_op = oy_reg; end
            4'd5:    begin x_op = dz_reg; y_op = oz_reg; end
            4'd6:    begin x_op = ox_reg; y_op = ox_reg; end
            4'd7:    begin x_op = oy_reg; y_op = oy_reg; end
            default: begin x_op = oz_reg; y_op = oz_reg; end
        endcase
        x_neg = -x_op;
        y_neg = -y_op;
        x_mag = x_op[CW-1] ? x_neg : x_op;
        y_mag = y_op[CW-1] ? y_neg : y_op;
    end

    // Signed accumulation of a product into the running dot sum.
    always_comb begin
        prod_ext  = {{(SUM_W-2*CW){1'b0}}, mul_prod[2*CW-1:0]};
        term      = (x_op[CW-1] ^ y_op[CW-1]) ? -prod_ext : prod_ext;
        acc_total = sum_reg + term;
        coef_now  = acc_total[SUM_W-1:FRAC_BITS];
    end

    // Magnitudes and range checks of the coefficients.
    always_comb begin
        h_neg  = -h_reg;
        c_neg  = -c_reg;
        h_mag  = h_reg[COEF_W-1] ? h_neg[MAG_W-1:0] : h_reg[MAG_W-1:0];
        c_mag  = c_reg[COEF_W-1] ? c_neg[MAG_W-1:0] : c_reg[MAG_W-1:0];
        a_ok   = !a_reg[COEF_W-1] && (a_reg != '0);
        idx_ok = ({{(32-IW){1'b0}}, idx_reg} < 32'(MAX_SPHERES));
        c_le0  = c_reg[COEF_W-1] || (c_reg == '0);
    end

    // Multiplier operands by phase.
    always_comb begin
        case (state_reg)
            S_HH:    begin mul_a = h_mag;               mul_b = h_mag; end
            S_AC:    begin mul_a = a_reg[MAG_W-1:0];    mul_b = c_mag; end
            default: begin
                mul_a = {{(MAG_W-CW){1'b0}}, x_mag};
                mul_b = {{(MAG_W-CW){1'b0}}, y_mag};
            end
        endcase
        mul_start  = ((state_reg == S_DOT) || (state_reg == S_HH) || (state_reg == S_AC))
                     && !issued_reg && !mul_stat.busy;
        sqrt_start = (state_reg == S_SQRT) && !issued_reg && !sqrt_stat.busy;
        div_start  = ((state_reg == S_DIV_N) || (state_reg == S_DIV_F))
                     && !issued_reg && !div_stat.busy;
    end

    // Discriminant from h*h and a*|c|.
    always_comb begin
        ac       = mul_prod;
        d_sum    = {2'b00, hh_reg} + {2'b00, ac};
        d_diff   = {2'b00, hh_reg} - {2'b00, ac};
        disc_neg = !c_le0 && (hh_reg < ac);
    end

    // Root numerators -h - s and -h + s.
    always_comb begin
        h_ext  = {{(N_W+1-COEF_W){h_reg[COEF_W-1]}}, h_reg};
        s_ext  = {2'b00, sqrt_root};
        nn_now = -h_ext - s_ext;
        nf_now = -h_ext + s_ext;
    end

    // Divider operand and saturated floor quotient.
    always_comb begin
        n_sel        = (state_reg == S_DIV_F) ? nf_reg : nn_reg;
        n_neg        = -n_sel;
        n_mag        = n_sel[N_W] ? n_neg[N_W-1:0] : n_sel[N_W-1:0];
        div_dividend = {n_mag, {FRAC_BITS{1'b0}}};
        q_hi_nz      = |div_q[DV_W-1:DW-1];
        q_lo         = div_q[DW-1:0];
        if (!n_sel[N_W]) begin
            t_sat = q_hi_nz ? rsnh_pkg::SAT_MAX : q_lo;
        end else if (q_hi_nz) begin
            t_sat = rsnh_pkg::SAT_MIN;
        end else begin
            t_sat = div_rem_nz ? ~q_lo : (~q_lo + 1'b1);
        end
    end

    // Candidate root and nearest-hit update.
    always_comb begin
        has_cand = 1'b1;
        if (!tn_reg[DW-1]) begin
            cand = tn_reg;
        end else if (!tf_reg[DW-1]) begin
            cand = tf_reg;
        end else begin
            cand     = '0;
            has_cand = 1'b0;
        end
        upd       = valid_reg && has_cand && (!best_found_reg || (cand < best_dist_reg));
        new_dist  = upd ? cand : best_dist_reg;
        new_sph   = upd ? idx_reg : best_sph_reg;
        new_found = upd || best_found_reg;
        out_free  = !m_valid_reg || m_ready;
    end

    // Sequencer, nearest-hit state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            k_reg          <= '0;
            best_dist_reg  <= '0;
            best_sph_reg   <= '0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // A new result in the done state refills the register instead.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_start || sqrt_start || div_start) begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ox_reg     <= s_origin_x;
                        oy_reg     <= s_origin_y;
                        oz_reg     <= s_origin_z;
                        dx_reg     <= s_dir_x;
                        dy_reg     <= s_dir_y;
                        dz_reg     <= s_dir_z;
                        idx_reg    <= s_sphere_index;
                        last_reg   <= s_last_sphere;
                        tn_reg     <= '0;
                        tf_reg     <= '0;
                        valid_reg  <= 1'b0;
                        sum_reg    <= '0;
                        k_reg      <= '0;
                        issued_reg <= 1'b0;
                        state_reg  <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (mul_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        k_reg      <= k_reg + 1'b1;
                        if (k_reg == K_A_LAST) begin
                            a_reg   <= coef_now;
                            sum_reg <= '0;
                        end else if (k_reg == K_H_LAST) begin
                            h_reg   <= coef_now;
                            sum_reg <= '0;
                        end else begin
                            sum_reg <= acc_total;
                            if (k_reg == K_C_LAST) begin
                                c_reg     <= coef_now - ONE_Q;
                                state_reg <= S_CHECK;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    state_reg <= (a_ok && idx_ok) ? S_HH : S_DONE;
                end
                S_HH: begin
                    if (mul_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        hh_reg     <= mul_prod;
                        state_reg  <= S_AC;
                    end
                end
                S_AC: begin
                    if (mul_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        d_reg      <= c_le0 ? d_sum : d_diff;
                        state_reg  <= disc_neg ? S_DONE : S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        nn_reg     <= nn_now;
                        nf_reg     <= nf_now;
                        state_reg  <= S_DIV_N;
                    end
                end
                S_DIV_N: begin
                    if (div_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        tn_reg     <= t_sat;
                        state_reg  <= S_DIV_F;
                    end
                end
                S_DIV_F: begin
                    if (div_stat.done && issued_reg) begin
                        issued_reg <= 1'b0;
                        tf_reg     <= t_sat;
                        valid_reg  <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_root_near_reg     <= tn_reg;
                        m_root_far_reg      <= tf_reg;
                        m_roots_valid_reg   <= valid_reg;
                        m_best_distance_reg <= new_dist;
                        m_best_sphere_reg   <= new_sph;
                        m_best_valid_reg    <= new_found;
                        m_ray_done_reg      <= last_reg;
                        if (last_reg) begin
                            best_dist_reg  <= '0;
                            best_sph_reg   <= '0;
                            best_found_reg <= 1'b0;
                        end else begin
                            best_dist_reg  <= new_dist;
                            best_sph_reg   <= new_sph;
                            best_found_reg <= new_found;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Shared serial multiplier for dot products, h*h and a*|c|.
    rsnh_serial_mul #(
        .W (MAG_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    // Serial square root of the discriminant.
    rsnh_serial_sqrt #(
        .R_W (ROOT_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .d_in    (d_reg),
        .stat    (sqrt_stat),
        .root    (sqrt_root)
    );

    // Serial divider for both roots.
    rsnh_serial_div #(
        .DV_W (DV_W),
        .DS_W (MAG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (a_reg[MAG_W-1:0]),
        .stat     (div_stat),
        .quotient (div_q),
        .rem_nz   (div_rem_nz)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_root_near     = m_root_near_reg;
    assign m_root_far      = m_root_far_reg;
    assign m_roots_valid   = m_roots_valid_reg;
    assign m_best_distance = m_best_distance_reg;
    assign m_best_sphere   = m_best_sphere_reg;
    assign m_best_valid    = m_best_valid_reg;
    assign m_ray_done      = m_ray_done_reg;

endmodule
